FILE: sv/kal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_pkg: shared types, codes and microprogram
// Operation, operand and flow codes for the tracker sequencer and datapath,
// the command and status bundles, and the step table that the controller runs.
// ----------------------------------------------------------------------------
package kal_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_TIME_STEP   = 3'd0;
    localparam logic [2:0] REG_MEAS_NOISE  = 3'd1;
    localparam logic [2:0] REG_PROC_POS    = 3'd2;
    localparam logic [2:0] REG_PROC_CROSS  = 3'd3;
    localparam logic [2:0] REG_PROC_VEL    = 3'd4;
    localparam logic [2:0] REG_START_POS   = 3'd5;
    localparam logic [2:0] REG_START_VEL   = 3'd6;

    // configuration reset values (dt = 0.01, R = 1.0, x0 = 1.234, v0 = 1.001)
    localparam logic [30:0] TIME_STEP_RST  = 31'd655;
    localparam logic [30:0] MEAS_NOISE_RST = 31'd65536;
    localparam logic [31:0] START_POS_RST  = 32'd80871;
    localparam logic [31:0] START_VEL_RST  = 32'd65602;

    // datapath operations
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_MUL   = 4'd1;  // product register = a * b
    localparam logic [3:0] OP_MWB   = 4'd2;  // dst = scaled, saturated product
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_HALF  = 4'd5;
    localparam logic [3:0] OP_DIV   = 4'd6;  // start divider with a / b
    localparam logic [3:0] OP_DIVWB = 4'd7;  // dst = quotient
    localparam logic [3:0] OP_CHK   = 4'd8;  // latch innovation variance check

    // operand and destination selects
    localparam logic [4:0] SEL_ZERO = 5'd0;
    localparam logic [4:0] SEL_DT   = 5'd1;
    localparam logic [4:0] SEL_POS  = 5'd2;
    localparam logic [4:0] SEL_VEL  = 5'd3;
    localparam logic [4:0] SEL_CA   = 5'd4;
    localparam logic [4:0] SEL_CB   = 5'd5;
    localparam logic [4:0] SEL_CC   = 5'd6;
    localparam logic [4:0] SEL_U    = 5'd7;
    localparam logic [4:0] SEL_Z    = 5'd8;
    localparam logic [4:0] SEL_R    = 5'd9;
    localparam logic [4:0] SEL_QPP  = 5'd10;
    localparam logic [4:0] SEL_QPV  = 5'd11;
    localparam logic [4:0] SEL_QVV  = 5'd12;
    localparam logic [4:0] SEL_H    = 5'd13;
    localparam logic [4:0] SEL_XP   = 5'd14;
    localparam logic [4:0] SEL_VP   = 5'd15;
    localparam logic [4:0] SEL_DB   = 5'd16;
    localparam logic [4:0] SEL_DC   = 5'd17;
    localparam logic [4:0] SEL_AP   = 5'd18;
    localparam logic [4:0] SEL_BP   = 5'd19;
    localparam logic [4:0] SEL_CP   = 5'd20;
    localparam logic [4:0] SEL_S    = 5'd21;
    localparam logic [4:0] SEL_K0   = 5'd22;
    localparam logic [4:0] SEL_K1   = 5'd23;
    localparam logic [4:0] SEL_E    = 5'd24;
    localparam logic [4:0] SEL_M    = 5'd25;

    // sequencing of a step
    localparam logic [2:0] FL_NEXT   = 3'd0;
    localparam logic [2:0] FL_DIV    = 3'd1;
    localparam logic [2:0] FL_BRANCH = 3'd2;
    localparam logic [2:0] FL_JUMP   = 3'd3;
    localparam logic [2:0] FL_FINISH = 3'd4;

    localparam logic [5:0] ERR_PC = 6'd47;
    localparam logic [5:0] END_PC = 6'd54;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dst;
        logic [2:0] flow;
    } kal_ucode_t;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dst;
        logic       load_in;
        logic       load_out;
    } kal_cmd_t;

    typedef struct packed {
        logic err;
        logic div_done;
        logic out_busy;
    } kal_status_t;

    function automatic kal_ucode_t ucode(input logic [5:0] pc);
        kal_ucode_t u;
        u = '{OP_NOP, SEL_ZERO, SEL_ZERO, SEL_ZERO, FL_NEXT};
        case (pc)
            // half dt squared
            6'd0:  u = '{OP_MUL,   SEL_DT,   SEL_DT,   SEL_ZERO, FL_NEXT};
            6'd1:  u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_H,    FL_NEXT};
            6'd2:  u = '{OP_HALF,  SEL_H,    SEL_ZERO, SEL_H,    FL_NEXT};
            // predicted position
            6'd3:  u = '{OP_MUL,   SEL_DT,   SEL_VEL,  SEL_ZERO, FL_NEXT};
            6'd4:  u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd5:  u = '{OP_ADD,   SEL_POS,  SEL_M,    SEL_XP,   FL_NEXT};
            6'd6:  u = '{OP_MUL,   SEL_H,    SEL_U,    SEL_ZERO, FL_NEXT};
            6'd7:  u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd8:  u = '{OP_ADD,   SEL_XP,   SEL_M,    SEL_XP,   FL_NEXT};
            // predicted velocity
            6'd9:  u = '{OP_MUL,   SEL_DT,   SEL_U,    SEL_ZERO, FL_NEXT};
            6'd10: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd11: u = '{OP_ADD,   SEL_VEL,  SEL_M,    SEL_VP,   FL_NEXT};
            // predicted covariance
            6'd12: u = '{OP_MUL,   SEL_DT,   SEL_CB,   SEL_ZERO, FL_NEXT};
            6'd13: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_DB,   FL_NEXT};
            6'd14: u = '{OP_MUL,   SEL_DT,   SEL_CC,   SEL_ZERO, FL_NEXT};
            6'd15: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_DC,   FL_NEXT};
            6'd16: u = '{OP_ADD,   SEL_CA,   SEL_DB,   SEL_AP,   FL_NEXT};
            6'd17: u = '{OP_ADD,   SEL_AP,   SEL_DB,   SEL_AP,   FL_NEXT};
            6'd18: u = '{OP_MUL,   SEL_DT,   SEL_DC,   SEL_ZERO, FL_NEXT};
            6'd19: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd20: u = '{OP_ADD,   SEL_AP,   SEL_M,    SEL_AP,   FL_NEXT};
            6'd21: u = '{OP_ADD,   SEL_AP,   SEL_QPP,  SEL_AP,   FL_NEXT};
            6'd22: u = '{OP_ADD,   SEL_CB,   SEL_DC,   SEL_BP,   FL_NEXT};
            6'd23: u = '{OP_ADD,   SEL_BP,   SEL_QPV,  SEL_BP,   FL_NEXT};
            6'd24: u = '{OP_ADD,   SEL_CC,   SEL_QVV,  SEL_CP,   FL_NEXT};
            6'd25: u = '{OP_ADD,   SEL_CP,   SEL_R,    SEL_S,    FL_NEXT};
            6'd26: u = '{OP_CHK,   SEL_ZERO, SEL_ZERO, SEL_ZERO, FL_BRANCH};
            // gains
            6'd27: u = '{OP_DIV,   SEL_BP,   SEL_S,    SEL_ZERO, FL_DIV};
            6'd28: u = '{OP_DIVWB, SEL_ZERO, SEL_ZERO, SEL_K0,   FL_NEXT};
            6'd29: u = '{OP_DIV,   SEL_CP,   SEL_S,    SEL_ZERO, FL_DIV};
            6'd30: u = '{OP_DIVWB, SEL_ZERO, SEL_ZERO, SEL_K1,   FL_NEXT};
            // state update
            6'd31: u = '{OP_SUB,   SEL_Z,    SEL_VP,   SEL_E,    FL_NEXT};
            6'd32: u = '{OP_MUL,   SEL_K0,   SEL_E,    SEL_ZERO, FL_NEXT};
            6'd33: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd34: u = '{OP_ADD,   SEL_XP,   SEL_M,    SEL_POS,  FL_NEXT};
            6'd35: u = '{OP_MUL,   SEL_K1,   SEL_E,    SEL_ZERO, FL_NEXT};
            6'd36: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd37: u = '{OP_ADD,   SEL_VP,   SEL_M,    SEL_VEL,  FL_NEXT};
            // covariance update
            6'd38: u = '{OP_MUL,   SEL_K0,   SEL_BP,   SEL_ZERO, FL_NEXT};
            6'd39: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd40: u = '{OP_SUB,   SEL_AP,   SEL_M,    SEL_CA,   FL_NEXT};
            6'd41: u = '{OP_MUL,   SEL_K0,   SEL_CP,   SEL_ZERO, FL_NEXT};
            6'd42: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd43: u = '{OP_SUB,   SEL_BP,   SEL_M,    SEL_CB,   FL_NEXT};
            6'd44: u = '{OP_MUL,   SEL_K1,   SEL_CP,   SEL_ZERO, FL_NEXT};
            6'd45: u = '{OP_MWB,   SEL_ZERO, SEL_ZERO, SEL_M,    FL_NEXT};
            6'd46: u = '{OP_SUB,   SEL_CP,   SEL_M,    SEL_CC,   FL_JUMP};
            // variance not positive: keep the prediction
            6'd47: u = '{OP_ADD,   SEL_XP,   SEL_ZERO, SEL_POS,  FL_NEXT};
            6'd48: u = '{OP_ADD,   SEL_VP,   SEL_ZERO, SEL_VEL,  FL_NEXT};
            6'd49: u = '{OP_ADD,   SEL_AP,   SEL_ZERO, SEL_CA,   FL_NEXT};
            6'd50: u = '{OP_ADD,   SEL_BP,   SEL_ZERO, SEL_CB,   FL_NEXT};
            6'd51: u = '{OP_ADD,   SEL_CP,   SEL_ZERO, SEL_CC,   FL_NEXT};
            6'd52: u = '{OP_ADD,   SEL_ZERO, SEL_ZERO, SEL_K0,   FL_NEXT};
            6'd53: u = '{OP_ADD,   SEL_ZERO, SEL_ZERO, SEL_K1,   FL_NEXT};
            // hand the result to the output register
            6'd54: u = '{OP_NOP,   SEL_ZERO, SEL_ZERO, SEL_ZERO, FL_FINISH};
            default: u = '{OP_NOP, SEL_ZERO, SEL_ZERO, SEL_ZERO, FL_FINISH};
        endcase
        return u;
    endfunction

endpackage

FILE: sv/kal_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_if: tracker channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface kal_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] control_accel;
    logic signed [31:0] measured_velocity;

    modport source (output valid, control_accel, measured_velocity, input ready);
    modport sink   (input valid, control_accel, measured_velocity, output ready);
endinterface

interface kal_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] gain_position;
    logic signed [31:0] gain_velocity;
    logic               div_error;

    modport source (output valid, est_position, est_velocity, gain_position,
                    gain_velocity, div_error, input ready);
    modport sink   (input valid, est_position, est_velocity, gain_position,
                    gain_velocity, div_error, output ready);
endinterface

interface kal_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/kal_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_div: serial fixed-point divider
// Restoring division of (num << FRAC_BITS) by a positive divisor, one quotient
// bit per cycle, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module kal_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quotient
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] POS_LIM = NW'(32'h7FFF_FFFF);
    localparam logic [NW-1:0] NEG_LIM = NW'(32'h8000_0000);

    logic [NW-1:0] quo_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [31:0]   result_reg;

    logic [31:0] num_mag;
    logic [33:0] trial;
    logic        qbit;
    logic [31:0] rem_next;

    assign num_mag = num[31] ? (~num + 32'd1) : num;

    // one restoring step
    always_comb
    begin
        trial    = {1'b0, rem_reg, quo_reg[NW-1]} - {2'b00, den_reg};
        qbit     = ~trial[33];
        rem_next = qbit ? trial[31:0] : {rem_reg[30:0], quo_reg[NW-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= {num_mag, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                den_reg  <= den;
                neg_reg  <= num[31];
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    quo_reg <= {quo_reg[NW-2:0], qbit};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - CW'(1);
                end
                else
                begin
                    // sign and saturation
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (neg_reg)
                        result_reg <= (quo_reg > NEG_LIM) ? 32'h8000_0000
                                                          : (~quo_reg[31:0] + 32'd1);
                    else
                        result_reg <= (quo_reg > POS_LIM) ? 32'h7FFF_FFFF
                                                          : quo_reg[31:0];
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = result_reg;
endmodule

FILE: sv/kal_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_dp: tracker datapath
// Configuration registers, filter state, temporaries, a shared multiplier,
// a saturating adder, the gain divider and the result register.
// ----------------------------------------------------------------------------
module kal_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kal_pkg::kal_cmd_t    cmd,
    output kal_pkg::kal_status_t status,
    input  logic signed [31:0]   control_accel,
    input  logic signed [31:0]   measured_velocity,
    kal_cfg_if.sink              cfg,
    kal_out_if.source            result
);
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
    localparam logic signed [63:0] MAX64 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MIN64 = -64'sh0000_0000_8000_0000;

    // configuration
    logic [30:0]        dt_reg, r_reg, qpp_reg, qvv_reg;
    logic signed [31:0] qpv_reg, start_pos_reg, start_vel_reg;
    // state
    logic signed [31:0] pos_reg, vel_reg, ca_reg, cb_reg, cc_reg;
    // sample and temporaries
    logic signed [31:0] u_reg, z_reg, h_reg, xp_reg, vp_reg, db_reg, dc_reg;
    logic signed [31:0] ap_reg, bp_reg, cp_reg, s_reg, k0_reg, k1_reg, e_reg, m_reg;
    logic               err_reg;
    logic signed [63:0] prod_reg;
    // result
    logic               out_valid_reg;
    logic signed [31:0] out_pos_reg, out_vel_reg, out_k0_reg, out_k1_reg;
    logic               out_err_reg;

    logic signed [31:0] op_a, op_b, wval;
    logic signed [32:0] sum;
    logic signed [63:0] scaled;
    logic signed [31:0] div_q;
    logic               div_done;
    logic               wr_en;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] pick(
        input logic [4:0] sel,
        input logic signed [31:0] dt, pos, vel, ca, cb, cc, u, z, r, qpp, qpv, qvv,
        input logic signed [31:0] h, xp, vp, db, dc, ap, bp, cp, s, k0, k1, e, m
    );
        logic signed [31:0] v;
        case (sel)
            kal_pkg::SEL_DT:  v = dt;
            kal_pkg::SEL_POS: v = pos;
            kal_pkg::SEL_VEL: v = vel;
            kal_pkg::SEL_CA:  v = ca;
            kal_pkg::SEL_CB:  v = cb;
            kal_pkg::SEL_CC:  v = cc;
            kal_pkg::SEL_U:   v = u;
            kal_pkg::SEL_Z:   v = z;
            kal_pkg::SEL_R:   v = r;
            kal_pkg::SEL_QPP: v = qpp;
            kal_pkg::SEL_QPV: v = qpv;
            kal_pkg::SEL_QVV: v = qvv;
            kal_pkg::SEL_H:   v = h;
            kal_pkg::SEL_XP:  v = xp;
            kal_pkg::SEL_VP:  v = vp;
            kal_pkg::SEL_DB:  v = db;
            kal_pkg::SEL_DC:  v = dc;
            kal_pkg::SEL_AP:  v = ap;
            kal_pkg::SEL_BP:  v = bp;
            kal_pkg::SEL_CP:  v = cp;
            kal_pkg::SEL_S:   v = s;
            kal_pkg::SEL_K0:  v = k0;
            kal_pkg::SEL_K1:  v = k1;
            kal_pkg::SEL_E:   v = e;
            kal_pkg::SEL_M:   v = m;
            default:          v = '0;
        endcase
        return v;
    endfunction

    // operand selection
    always_comb
    begin
        op_a = pick(cmd.src_a, {1'b0, dt_reg}, pos_reg, vel_reg, ca_reg, cb_reg,
                    cc_reg, u_reg, z_reg, {1'b0, r_reg}, {1'b0, qpp_reg}, qpv_reg,
                    {1'b0, qvv_reg}, h_reg, xp_reg, vp_reg, db_reg, dc_reg, ap_reg,
                    bp_reg, cp_reg, s_reg, k0_reg, k1_reg, e_reg, m_reg);
        op_b = pick(cmd.src_b, {1'b0, dt_reg}, pos_reg, vel_reg, ca_reg, cb_reg,
                    cc_reg, u_reg, z_reg, {1'b0, r_reg}, {1'b0, qpp_reg}, qpv_reg,
                    {1'b0, qvv_reg}, h_reg, xp_reg, vp_reg, db_reg, dc_reg, ap_reg,
                    bp_reg, cp_reg, s_reg, k0_reg, k1_reg, e_reg, m_reg);
    end

    // write-back value
    always_comb
    begin
        scaled = prod_reg >>> FRAC_BITS;
        sum    = (cmd.op == kal_pkg::OP_SUB) ? ({op_a[31], op_a} - {op_b[31], op_b})
                                             : ({op_a[31], op_a} + {op_b[31], op_b});
        wr_en  = 1'b1;
        case (cmd.op)
            kal_pkg::OP_MWB:
                wval = (scaled > MAX64) ? 32'sh7FFF_FFFF :
                       (scaled < MIN64) ? 32'sh8000_0000 : scaled[31:0];
            kal_pkg::OP_ADD,
            kal_pkg::OP_SUB:   wval = sat33(sum);
            kal_pkg::OP_HALF:  wval = op_a >>> 1;
            kal_pkg::OP_DIVWB: wval = div_q;
            default:
            begin
                wval  = '0;
                wr_en = 1'b0;
            end
        endcase
    end

    kal_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == kal_pkg::OP_DIV),
        .num      (op_a),
        .den      (op_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // configuration and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg        <= kal_pkg::TIME_STEP_RST;
            r_reg         <= kal_pkg::MEAS_NOISE_RST;
            qpp_reg       <= '0;
            qpv_reg       <= '0;
            qvv_reg       <= '0;
            start_pos_reg <= kal_pkg::START_POS_RST;
            start_vel_reg <= kal_pkg::START_VEL_RST;
            pos_reg       <= kal_pkg::START_POS_RST;
            vel_reg       <= kal_pkg::START_VEL_RST;
            ca_reg        <= ONE;
            cb_reg        <= '0;
            cc_reg        <= ONE;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    kal_pkg::REG_TIME_STEP:  dt_reg  <= cfg.data[30:0];
                    kal_pkg::REG_MEAS_NOISE: r_reg   <= cfg.data[30:0];
                    kal_pkg::REG_PROC_POS:   qpp_reg <= cfg.data[30:0];
                    kal_pkg::REG_PROC_CROSS: qpv_reg <= cfg.data;
                    kal_pkg::REG_PROC_VEL:   qvv_reg <= cfg.data[30:0];
                    kal_pkg::REG_START_POS:
                    begin
                        start_pos_reg <= cfg.data;
                        pos_reg       <= cfg.data;
                    end
                    kal_pkg::REG_START_VEL:
                    begin
                        start_vel_reg <= cfg.data;
                        vel_reg       <= cfg.data;
                    end
                    default: ;
                endcase
            end
            if (wr_en)
            begin
                case (cmd.dst)
                    kal_pkg::SEL_POS: pos_reg <= wval;
                    kal_pkg::SEL_VEL: vel_reg <= wval;
                    kal_pkg::SEL_CA:  ca_reg  <= wval;
                    kal_pkg::SEL_CB:  cb_reg  <= wval;
                    kal_pkg::SEL_CC:  cc_reg  <= wval;
                    default: ;
                endcase
            end
        end
    end

    // temporaries and product
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            u_reg <= control_accel;
            z_reg <= measured_velocity;
        end
        if (cmd.op == kal_pkg::OP_MUL)
            prod_reg <= op_a * op_b;
        if (cmd.op == kal_pkg::OP_CHK)
            err_reg <= (s_reg[31] || (s_reg == '0));
        if (wr_en)
        begin
            case (cmd.dst)
                kal_pkg::SEL_H:  h_reg  <= wval;
                kal_pkg::SEL_XP: xp_reg <= wval;
                kal_pkg::SEL_VP: vp_reg <= wval;
                kal_pkg::SEL_DB: db_reg <= wval;
                kal_pkg::SEL_DC: dc_reg <= wval;
                kal_pkg::SEL_AP: ap_reg <= wval;
                kal_pkg::SEL_BP: bp_reg <= wval;
                kal_pkg::SEL_CP: cp_reg <= wval;
                kal_pkg::SEL_S:  s_reg  <= wval;
                kal_pkg::SEL_K0: k0_reg <= wval;
                kal_pkg::SEL_K1: k1_reg <= wval;
                kal_pkg::SEL_E:  e_reg  <= wval;
                kal_pkg::SEL_M:  m_reg  <= wval;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_pos_reg <= pos_reg;
            out_vel_reg <= vel_reg;
            out_k0_reg  <= k0_reg;
            out_k1_reg  <= k1_reg;
            out_err_reg <= err_reg;
        end
    end

    assign cfg.ready            = 1'b1;
    assign result.valid         = out_valid_reg;
    assign result.est_position  = out_pos_reg;
    assign result.est_velocity  = out_vel_reg;
    assign result.gain_position = out_k0_reg;
    assign result.gain_velocity = out_k1_reg;
    assign result.div_error     = out_err_reg;

    assign status.err      = s_reg[31] || (s_reg == '0);
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !result.ready;
endmodule

FILE: sv/kal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kal_ctrl: tracker sequencer
// Steps through the filter program, waits on the divider, branches on the
// variance check and hands the result to the output register.
// ----------------------------------------------------------------------------
module kal_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  kal_pkg::kal_status_t status,
    output kal_pkg::kal_cmd_t    cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [5:0] pc_reg, pc_next;
    kal_pkg::kal_ucode_t uc;

    assign uc           = kal_pkg::ucode(pc_reg);
    assign sample_ready = (state_reg == ST_IDLE);

    // next state and command
    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        cmd          = '0;
        cmd.op       = kal_pkg::OP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_in = 1'b1;
                    pc_next     = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.op    = uc.op;
                cmd.src_a = uc.src_a;
                cmd.src_b = uc.src_b;
                cmd.dst   = uc.dst;
                case (uc.flow)
                    kal_pkg::FL_NEXT:   pc_next = pc_reg + 6'd1;
                    kal_pkg::FL_DIV:    state_next = ST_DIV;
                    kal_pkg::FL_BRANCH: pc_next = status.err ? kal_pkg::ERR_PC
                                                             : pc_reg + 6'd1;
                    kal_pkg::FL_JUMP:   pc_next = kal_pkg::END_PC;
                    kal_pkg::FL_FINISH:
                    begin
                        if (!status.out_busy)
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    pc_next    = pc_reg + 6'd1;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end
endmodule

FILE: sv/kalman_two_state_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_two_state_tracker: constant-velocity Kalman filter
// Each sample request (acceleration, measured velocity) runs one predict and
// update step and yields one result request with the new position and
// velocity, both gains and a flag for a non-positive innovation variance.
//
// Channels: sample (sink), result (source), cfg (sink, always ready; write
// only while no sample is in flight). Register index i follows the list
// time_step, meas_noise, proc_noise_pos, proc_noise_cross, proc_noise_vel,
// start_position, start_velocity; the start registers also load the estimate.
// A normal pass runs 48 sequencer steps plus two serial divisions;
// a variance error skips the gains and the update. One sample is
// processed at a time; the next is taken the cycle after its result is
// loaded into the output register, and a stalled receiver holds that
// register. Reset restores the configuration registers, estimate and
// unit covariance at once.
// ----------------------------------------------------------------------------
module kalman_two_state_tracker #(
    parameter int FRAC_BITS = 16
) (
    input logic      clk,
    input logic      rst_n,
    kal_in_if.sink   sample,
    kal_out_if.source result,
    kal_cfg_if.sink  cfg
);
    kal_pkg::kal_cmd_t    cmd;
    kal_pkg::kal_status_t status;
    logic                 ready;

    assign sample.ready = ready;

    kal_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (ready),
        .status       (status),
        .cmd          (cmd)
    );

    kal_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .control_accel     (sample.control_accel),
        .measured_velocity (sample.measured_velocity),
        .cfg               (cfg),
        .result            (result)
    );
endmodule
